// File: design/gm_pkg.sv
// ----------------------------------------------------------------------------
// gm_pkg: shared definitions for the glob matcher
// Store depth, character codes, item codes and the cell control bundle.
// ----------------------------------------------------------------------------
package gm_pkg;

	localparam int GM_DEPTH = 32;
	localparam int GM_LEN_W = $clog2(GM_DEPTH + 1);

	localparam logic [7:0] CHAR_STAR  = 8'd42;
	localparam logic [7:0] CHAR_QMARK = 8'd63;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SUBJ = 1'b1;

	typedef logic [7:0]          char_t;
	typedef logic [GM_LEN_W-1:0] len_t;

	typedef struct packed {
		logic load;      // pattern byte transfer
		logic new_pat;   // load that opens a fresh pattern
		logic sub;       // subject byte transfer
		logic sub_last;  // subject byte that ends the subject
	} cell_ctl_t;

endpackage

// File: design/gm_cell.sv
// ----------------------------------------------------------------------------
// gm_cell: one pattern position
// Holds the pattern byte, the active bit and the restart bit for its
// position, and hands a match token and a leading-star token to the next cell.
// ----------------------------------------------------------------------------
module gm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gm_pkg::cell_ctl_t ctl,
	input  logic              sel,        // this position is written by the load
	input  logic              live,       // position lies inside the pattern
	input  logic              lead_seed,  // set only on the first cell
	input  gm_pkg::char_t     ch,
	input  logic              lead_in,
	input  logic              closed_in,  // star-closed next state for this position
	output logic              star,
	output logic              keep,
	output logic              fwd,
	output logic              lead_out
);
	import gm_pkg::*;

	char_t pat_q;
	logic  act_q;
	logic  lead_q;
	logic  lead_base;
	logic  lead_next;
	logic  is_star;

	assign is_star   = (pat_q == CHAR_STAR);
	assign lead_base = ctl.new_pat ? lead_seed : lead_q;
	assign lead_next = lead_base | lead_in;
	// a leading run of stars reaches one position further
	assign lead_out  = sel & (ch == CHAR_STAR) & lead_base;

	assign star = live & is_star;
	assign keep = live & act_q & is_star;
	assign fwd  = live & act_q & ~is_star & ((pat_q == CHAR_QMARK) | (pat_q == ch));

	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			pat_q <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= lead_seed;
			lead_q <= lead_seed;
		end else if (ctl.load) begin
			act_q  <= lead_next;
			lead_q <= lead_next;
		end else if (ctl.sub) begin
			act_q <= ctl.sub_last ? lead_q : closed_in;
		end
	end

endmodule

// File: design/gm_star_close.sv
// ----------------------------------------------------------------------------
// gm_star_close: empty-run closure over star positions
// An active star position also activates the next one, along whole runs of
// stars. The run propagation is an add: carries ripple through star bits.
// ----------------------------------------------------------------------------
module gm_star_close (
	input  logic [gm_pkg::GM_DEPTH:0]   raw,
	input  logic [gm_pkg::GM_DEPTH-1:0] star,
	output logic [gm_pkg::GM_DEPTH:0]   closed
);
	import gm_pkg::*;

	logic [GM_DEPTH:0]   prop;
	logic [GM_DEPTH:0]   gen;
	logic [GM_DEPTH+1:0] sum;
	logic [GM_DEPTH+1:0] carry;

	assign prop  = {1'b0, star};
	assign gen   = prop & raw;
	// carry into bit j+1 = star[j] & (raw[j] | carry into j)
	assign sum   = {1'b0, prop} + {1'b0, gen};
	assign carry = sum ^ {1'b0, prop} ^ {1'b0, gen};

	assign closed = raw | carry[GM_DEPTH:0];

endmodule

// File: design/wildcard_glob_matcher_top.sv
// Result: a subject's last byte gives its result in the output register in the
// cycle after its transfer; other transfers give no result.
// Throughput: one byte per cycle while no result waits stalled in the output
// register; cells and star-closure adder update the active position row per byte.
// Reset: pattern empty and closed, overflow clear, only position 0 active,
// output register empty.
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top: streaming glob matcher with '*' and '?'
// Pattern bytes load into a row of cells; subject bytes advance an active
// position vector one step per byte, reporting a match on the last byte.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          operation,
	input  gm_pkg::char_t ch,
	input  logic          last,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          matched,
	output logic          pattern_overflow
);
	import gm_pkg::*;

	cell_ctl_t ctl;
	logic      acc;

	len_t len_q;
	len_t base_len;
	logic ovf_q;
	logic ovf_base;
	logic pat_closed_q;

	logic out_valid_q;
	logic matched_q;
	logic out_ovf_q;

	logic [GM_DEPTH-1:0] star;
	logic [GM_DEPTH-1:0] keep;
	logic [GM_DEPTH-1:0] fwd;
	logic [GM_DEPTH-1:0] lead_out;
	logic [GM_DEPTH:0]   raw;
	logic [GM_DEPTH:0]   closed;
	logic                hit;

	assign in_ready = ~out_valid_q | out_ready;
	assign acc      = in_valid & in_ready;

	always_comb begin
		ctl          = '0;
		ctl.load     = acc & (operation == OP_LOAD);
		ctl.new_pat  = ctl.load & pat_closed_q;
		ctl.sub      = acc & (operation == OP_SUBJ);
		ctl.sub_last = ctl.sub & last;
	end

	assign base_len = ctl.new_pat ? '0 : len_q;
	assign ovf_base = ctl.new_pat ? 1'b0 : ovf_q;

	for (genvar i = 0; i < GM_DEPTH; i++) begin : g_cell
		logic lead_in;
		if (i == 0) begin : g_first
			assign lead_in = 1'b0;
		end else begin : g_rest
			assign lead_in = lead_out[i-1];
		end

		gm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (base_len == len_t'(i)),
			.live      (len_q > len_t'(i)),
			.lead_seed ((i == 0) ? 1'b1 : 1'b0),
			.ch        (ch),
			.lead_in   (lead_in),
			.closed_in (closed[i]),
			.star      (star[i]),
			.keep      (keep[i]),
			.fwd       (fwd[i]),
			.lead_out  (lead_out[i])
		);
	end

	// next state before closure: stars hold, matches step one position on
	assign raw = {1'b0, keep} | {fwd, 1'b0};

	gm_star_close u_close (
		.raw    (raw),
		.star   (star),
		.closed (closed)
	);

	// the end position is never fed back, so its state is read straight from closed
	assign hit = closed[len_q] & (len_q != '0) & ~ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			ovf_q        <= 1'b0;
			pat_closed_q <= 1'b1;
		end else if (ctl.load) begin
			if (base_len < len_t'(GM_DEPTH)) begin
				len_q <= base_len + len_t'(1);
				ovf_q <= ovf_base;
			end else begin
				len_q <= base_len;
				ovf_q <= 1'b1;
			end
			pat_closed_q <= last;
		end else if (ctl.sub) begin
			pat_closed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.sub_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sub_last) begin
			matched_q <= hit;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = out_ovf_q;

endmodule

// File: design/gm_checker.sv
// ----------------------------------------------------------------------------
// gm_checker: port-level checks for the glob matcher
// Watches the top level's handshakes and result fields.
// ----------------------------------------------------------------------------
module gm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          operation,
	input logic          last,
	input logic          out_valid,
	input logic          out_ready,
	input logic          matched,
	input logic          pattern_overflow
);
	import gm_pkg::*;

	// a held result keeps its fields until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) &&
		$stable(pattern_overflow))
		else $error("result changed while stalled");

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pattern_overflow |-> !matched)
		else $error("match reported with overflowed pattern");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_SUBJ && last |=> out_valid)
		else $error("subject end gave no result");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_LOAD |=> !out_valid)
		else $error("pattern load gave a result");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result register full");

endmodule

bind wildcard_glob_matcher_top gm_checker u_gm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.operation        (operation),
	.last             (last),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.matched          (matched),
	.pattern_overflow (pattern_overflow)
);
